// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/jted_pkg.sv -----
// types and constants of the japanese text encoding detector
`default_nettype none

package jted_pkg;

    // result codes
    typedef enum logic [2:0] {
        ENC_UNKNOWN = 3'd0,
        ENC_ASCII   = 3'd1,
        ENC_JIS     = 3'd2,
        ENC_SJIS    = 3'd3,
        ENC_EUC     = 3'd4,
        ENC_UTF     = 3'd5
    } t_enc_code;

    // bit positions in the valid flags
    localparam int unsigned FLAG_ASCII = 0;
    localparam int unsigned FLAG_JIS   = 1;
    localparam int unsigned FLAG_SJIS  = 2;
    localparam int unsigned FLAG_EUC   = 3;
    localparam int unsigned FLAG_UTF   = 4;
    localparam int unsigned FLAG_W     = 5;

    typedef enum logic [1:0] {
        EUC_PH_LEAD   = 2'd0,
        EUC_PH_TRAIL1 = 2'd1,
        EUC_PH_TRAIL2 = 2'd2,
        EUC_PH_BAD    = 2'd3
    } t_euc_phase;

    typedef enum logic [1:0] {
        EUC_NONE  = 2'd0,
        EUC_TWO   = 2'd1,
        EUC_KANA  = 2'd2,
        EUC_THREE = 2'd3
    } t_euc_kind;

    typedef enum logic [1:0] {
        UTF_PH_LEAD = 2'd0,
        UTF_PH_C1   = 2'd1,
        UTF_PH_C2   = 2'd2,
        UTF_PH_C3   = 2'd3
    } t_utf_phase;

    typedef enum logic [2:0] {
        UTF_NONE = 3'd0,
        UTF_2B   = 3'd1,
        UTF_E0   = 3'd2,
        UTF_3B   = 3'd3,
        UTF_F0   = 3'd4,
        UTF_4B   = 3'd5,
        UTF_F4   = 3'd6
    } t_utf_kind;

    typedef enum logic {
        SJIS_PH_LEAD  = 1'b0,
        SJIS_PH_TRAIL = 1'b1
    } t_sjis_phase;

    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        t_sjis_phase       sjis_phase;
        t_euc_phase        euc_phase;
        t_euc_kind         euc_kind;
        t_utf_phase        utf_phase;
        t_utf_kind         utf_kind;
    } t_val_state;

    localparam t_val_state VAL_STATE_RESET = '{
        flags:      {FLAG_W{1'b1}},
        sjis_phase: SJIS_PH_LEAD,
        euc_phase:  EUC_PH_LEAD,
        euc_kind:   EUC_NONE,
        utf_phase:  UTF_PH_LEAD,
        utf_kind:   UTF_NONE
    };

endpackage

`default_nettype wire

// ----- hw/rtl/jted_validate.sv -----
// next state of the five encoding validators for one byte
`default_nettype none

module jted_validate (
    input  wire logic [7:0]          i_byte,
    input  wire jted_pkg::t_val_state i_state,
    output jted_pkg::t_val_state     o_state
);
    import jted_pkg::*;

    logic b_low;
    logic b_ascii_ok;
    logic b_sjis_lead;
    logic b_sjis_kana;
    logic b_sjis_trail;
    logic b_euc_ab;
    logic b_euc_hi;
    logic b_cont;
    logic [7:0] utf_lo;
    logic [7:0] utf_hi;

    assign b_low        = !i_byte[7];
    assign b_ascii_ok   = (i_byte >= 8'h20 && i_byte <= 8'h7e) ||
                          (i_byte >= 8'h09 && i_byte <= 8'h0d);
    assign b_sjis_lead  = (i_byte >= 8'h81 && i_byte <= 8'h9f) ||
                          (i_byte >= 8'he0 && i_byte <= 8'hef);
    assign b_sjis_kana  = i_byte >= 8'ha1 && i_byte <= 8'hdf;
    assign b_sjis_trail = (i_byte >= 8'h40 && i_byte <= 8'h7e) ||
                          (i_byte >= 8'h80 && i_byte <= 8'hfc);
    assign b_euc_ab     = i_byte >= 8'ha1 && i_byte <= 8'hfe;
    assign b_euc_hi     = i_byte >= 8'h81;
    assign b_cont       = i_byte >= 8'h80 && i_byte <= 8'hbf;

    // strict range of the first continuation byte
    always_comb begin
        utf_lo = 8'h80;
        utf_hi = 8'hbf;
        case (i_state.utf_kind)
            UTF_E0:  utf_lo = 8'ha0;
            UTF_F0:  utf_lo = 8'h90;
            UTF_F4:  utf_hi = 8'h8f;
            default: ;
        endcase
    end

    always_comb begin
        o_state = i_state;

        if (i_state.flags[FLAG_ASCII] && !b_ascii_ok) begin
            o_state.flags[FLAG_ASCII] = 1'b0;
        end

        if (i_state.flags[FLAG_JIS] && !b_low) begin
            o_state.flags[FLAG_JIS] = 1'b0;
        end

        if (i_state.flags[FLAG_SJIS]) begin
            unique case (i_state.sjis_phase)
                SJIS_PH_LEAD: begin
                    if (b_sjis_lead) begin
                        o_state.sjis_phase = SJIS_PH_TRAIL;
                    end else if (!b_low && !b_sjis_kana) begin
                        o_state.flags[FLAG_SJIS] = 1'b0;
                    end
                end
                SJIS_PH_TRAIL: begin
                    if (b_sjis_trail) begin
                        o_state.sjis_phase = SJIS_PH_LEAD;
                    end else begin
                        o_state.flags[FLAG_SJIS] = 1'b0;
                    end
                end
                default: o_state.flags[FLAG_SJIS] = 1'b0;
            endcase
        end

        if (i_state.flags[FLAG_EUC]) begin
            unique case (i_state.euc_phase)
                EUC_PH_LEAD: begin
                    o_state.euc_kind = EUC_NONE;
                    if (!b_low) begin
                        o_state.euc_phase = EUC_PH_TRAIL1;
                        if (b_euc_ab) begin
                            o_state.euc_kind = EUC_TWO;
                        end else if (i_byte == 8'h8e) begin
                            o_state.euc_kind = EUC_KANA;
                        end else if (i_byte == 8'h8f) begin
                            o_state.euc_kind = EUC_THREE;
                        end else begin
                            o_state.flags[FLAG_EUC] = 1'b0;
                        end
                    end
                end
                EUC_PH_TRAIL1: begin
                    if (i_state.euc_kind == EUC_TWO && b_euc_ab) begin
                        o_state.euc_phase = EUC_PH_LEAD;
                    end else if (i_state.euc_kind == EUC_KANA && b_euc_hi) begin
                        o_state.euc_phase = EUC_PH_LEAD;
                    end else if (i_state.euc_kind == EUC_THREE && b_euc_hi) begin
                        o_state.euc_phase = EUC_PH_TRAIL2;
                    end else begin
                        o_state.flags[FLAG_EUC] = 1'b0;
                    end
                end
                EUC_PH_TRAIL2: begin
                    if (b_euc_hi) begin
                        o_state.euc_phase = EUC_PH_LEAD;
                    end else begin
                        o_state.flags[FLAG_EUC] = 1'b0;
                    end
                end
                default: o_state.flags[FLAG_EUC] = 1'b0;
            endcase
        end

        if (i_state.flags[FLAG_UTF]) begin
            unique case (i_state.utf_phase)
                UTF_PH_LEAD: begin
                    o_state.utf_kind = UTF_NONE;
                    if (!b_low) begin
                        o_state.utf_phase = UTF_PH_C1;
                        if (i_byte >= 8'hc2 && i_byte <= 8'hdf) begin
                            o_state.utf_kind = UTF_2B;
                        end else if (i_byte == 8'he0) begin
                            o_state.utf_kind = UTF_E0;
                        end else if (i_byte >= 8'he1 && i_byte <= 8'hef) begin
                            o_state.utf_kind = UTF_3B;
                        end else if (i_byte == 8'hf0) begin
                            o_state.utf_kind = UTF_F0;
                        end else if (i_byte >= 8'hf1 && i_byte <= 8'hf3) begin
                            o_state.utf_kind = UTF_4B;
                        end else if (i_byte == 8'hf4) begin
                            o_state.utf_kind = UTF_F4;
                        end else begin
                            o_state.flags[FLAG_UTF] = 1'b0;
                        end
                    end
                end
                UTF_PH_C1: begin
                    if (i_state.utf_kind == UTF_NONE || i_state.utf_kind > UTF_F4 ||
                        i_byte < utf_lo || i_byte > utf_hi) begin
                        o_state.flags[FLAG_UTF] = 1'b0;
                    end else if (i_state.utf_kind == UTF_2B) begin
                        o_state.utf_phase = UTF_PH_LEAD;
                    end else begin
                        o_state.utf_phase = UTF_PH_C2;
                    end
                end
                UTF_PH_C2: begin
                    if (!b_cont) begin
                        o_state.flags[FLAG_UTF] = 1'b0;
                    end else if (i_state.utf_kind == UTF_E0 ||
                                 i_state.utf_kind == UTF_3B) begin
                        o_state.utf_phase = UTF_PH_LEAD;
                    end else if (i_state.utf_kind == UTF_F0 ||
                                 i_state.utf_kind == UTF_4B ||
                                 i_state.utf_kind == UTF_F4) begin
                        o_state.utf_phase = UTF_PH_C3;
                    end else begin
                        o_state.flags[FLAG_UTF] = 1'b0;
                    end
                end
                UTF_PH_C3: begin
                    if (b_cont && (i_state.utf_kind == UTF_F0 ||
                                   i_state.utf_kind == UTF_4B ||
                                   i_state.utf_kind == UTF_F4)) begin
                        o_state.utf_phase = UTF_PH_LEAD;
                    end else begin
                        o_state.flags[FLAG_UTF] = 1'b0;
                    end
                end
                default: o_state.flags[FLAG_UTF] = 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/japanese_text_encoding_detector.sv -----
// top level of the japanese text encoding detector
// Usage:
//   input channel (i_in_valid / o_in_stall) moves one byte of a string per
//   transfer together with i_is_last, which marks the final byte.
//   output channel (o_out_valid / i_out_stall) moves one result per string:
//   o_encoding_code and o_valid_mask, the flags still set at the end.
//   config channel (i_cfg_valid / o_cfg_ready) writes i_cfg_prefer_eucjp;
//   ready is always high, write only while the block is idle.
// Throughput: one byte per cycle unless o_in_stall; the validators and the
//   decision are one stage of logic between the state and result registers.
// Latency: the result is valid in the cycle after the last byte's transfer.
// A zero byte stops evaluation for the rest of the string; bytes beyond
//   MAX_LEN are ignored.
// Stall: while a result waits under i_out_stall, bytes that are not the
//   last are still taken; a last byte is held off until the result leaves.
// Reset (synchronous, active low) clears the validator state, the byte
//   count, the output valid and prefer_eucjp.
`default_nettype none

`include "assert_macros.svh"

module japanese_text_encoding_detector #(
    parameter int unsigned MAX_LEN = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_is_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_encoding_code,
    output logic [4:0]      o_valid_mask,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_prefer_eucjp
);
    import jted_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

    t_val_state        r_state;
    t_val_state        n_state;
    t_val_state        v_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_stopped;
    logic              n_stopped;
    logic              r_prefer_eucjp;
    logic              r_out_valid;
    t_enc_code         r_out_code;
    logic [FLAG_W-1:0] r_out_mask;
    t_enc_code         n_code;
    logic              in_xfer;
    logic              take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall && i_is_last;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign take        = !r_stopped && (i_text_byte != 8'h00) && (r_count < CNT_MAX);

    jted_validate u_validate (
        .i_byte  (i_text_byte),
        .i_state (r_state),
        .o_state (v_state)
    );

    always_comb begin
        n_state   = take ? v_state : r_state;
        n_count   = take ? r_count + CNT_W'(1) : r_count;
        n_stopped = r_stopped || (i_text_byte == 8'h00);
    end

    always_comb begin
        n_code = ENC_UNKNOWN;
        if (n_state.flags[FLAG_ASCII]) begin
            n_code = ENC_ASCII;
        end else if (n_state.flags[FLAG_JIS]) begin
            n_code = ENC_JIS;
        end else if (n_state.flags[FLAG_UTF]) begin
            n_code = ENC_UTF;
        end else if (r_prefer_eucjp) begin
            if (n_state.flags[FLAG_EUC]) begin
                n_code = ENC_EUC;
            end else if (n_state.flags[FLAG_SJIS]) begin
                n_code = ENC_SJIS;
            end
        end else begin
            if (n_state.flags[FLAG_SJIS]) begin
                n_code = ENC_SJIS;
            end else if (n_state.flags[FLAG_EUC]) begin
                n_code = ENC_EUC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= VAL_STATE_RESET;
            r_count        <= '0;
            r_stopped      <= 1'b0;
            r_prefer_eucjp <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_prefer_eucjp <= i_cfg_prefer_eucjp;
            end
            if (in_xfer && i_is_last) begin
                // string done: back to the reset state
                r_state   <= VAL_STATE_RESET;
                r_count   <= '0;
                r_stopped <= 1'b0;
            end else if (in_xfer) begin
                r_state   <= n_state;
                r_count   <= n_count;
                r_stopped <= n_stopped;
            end
            if (in_xfer && i_is_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_is_last) begin
            r_out_code <= n_code;
            r_out_mask <= n_state.flags;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_encoding_code = r_out_code;
    assign o_valid_mask    = r_out_mask;

    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_xfer && i_is_last, r_out_valid)
    `ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, in_xfer && i_is_last,
        r_count == '0 && !r_stopped && r_state.flags == {FLAG_W{1'b1}})
    `ASSERT_NEXT(a_stopped_holds_count, i_clk, i_rst_n, in_xfer && r_stopped && !i_is_last,
        r_count == $past(r_count))
    `ASSERT_IMPLIES(a_code_matches_mask, i_clk, i_rst_n, r_out_valid,
        (r_out_code == ENC_UNKNOWN) == (r_out_mask == '0))
    `ASSERT_HOLDS(a_count_bounded, i_clk, i_rst_n, r_count <= CNT_MAX)

endmodule

`default_nettype wire

// ----- dv/japanese_text_encoding_detector_tb.sv -----
// self-checking testbench for the japanese text encoding detector
module japanese_text_encoding_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jted_pkg::*;

    localparam int TEXT_MAX      = 256;
    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int LONG_HOLD     = 400;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } t_byte_xfer;

    typedef struct packed {
        t_enc_code  code;
        logic [4:0] mask;
    } t_verdict;

    typedef enum int {FL_ASCII, FL_JIS, FL_SJIS, FL_EUC, FL_UTF, FL_NOISE} t_flavor;

    logic       i_clk              = 1'b0;
    logic       i_rst_n            = 1'b0;
    logic       i_in_valid         = 1'b0;
    logic [7:0] i_text_byte        = 8'h00;
    logic       i_is_last          = 1'b0;
    logic       i_out_stall        = 1'b0;
    logic       i_cfg_valid        = 1'b0;
    logic       i_cfg_prefer_eucjp = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_encoding_code;
    logic [4:0] o_valid_mask;
    logic       o_cfg_ready;

    japanese_text_encoding_detector #(
        .MAX_LEN(TEXT_MAX)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_text_byte       (i_text_byte),
        .i_is_last         (i_is_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_encoding_code   (o_encoding_code),
        .o_valid_mask      (o_valid_mask),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_prefer_eucjp(i_cfg_prefer_eucjp)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // stimulus and expected results
    t_byte_xfer byte_q[$];
    t_verdict   verdict_q[$];
    logic [7:0] text_buf[$];
    int         queued_bytes = 0;
    int         fail_count   = 0;
    int         cycle_count  = 0;

    // side behavior
    bit         tx_idle_on = 1'b1;
    bit         rx_idle_on = 1'b1;
    int         tx_wait    = 0;
    int         rx_wait    = 0;
    int         hold_left  = 0;
    logic       long_hold  = 1'b0;
    logic       tx_offer;
    t_byte_xfer tx_item;
    t_verdict   seen_want;

    // shadow of the detector state
    logic [4:0]  flags;
    t_sjis_phase sj_ph;
    t_euc_phase  eu_ph;
    t_euc_kind   eu_kind;
    t_utf_phase  ut_ph;
    t_utf_kind   ut_kind;
    int          text_len;
    bit          halted;
    bit          prefer_euc = 1'b0;

    function automatic void reset_scan();
        flags    = '1;
        sj_ph    = SJIS_PH_LEAD;
        eu_ph    = EUC_PH_LEAD;
        eu_kind  = EUC_NONE;
        ut_ph    = UTF_PH_LEAD;
        ut_kind  = UTF_NONE;
        text_len = 0;
        halted   = 1'b0;
    endfunction

    function automatic bit sjis_takes(logic [7:0] b);
        if (sj_ph == SJIS_PH_LEAD) begin
            if (b < 8'h80) return 1'b1;
            if (b inside {[8'h81:8'h9f], [8'he0:8'hef]}) begin
                sj_ph = SJIS_PH_TRAIL;
                return 1'b1;
            end
            return b inside {[8'ha1:8'hdf]};
        end
        if (b inside {[8'h40:8'h7e], [8'h80:8'hfc]}) begin
            sj_ph = SJIS_PH_LEAD;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit euc_takes(logic [7:0] b);
        case (eu_ph)
            EUC_PH_LEAD: begin
                eu_kind = EUC_NONE;
                if (b < 8'h80) return 1'b1;
                eu_ph = EUC_PH_TRAIL1;
                if (b inside {[8'ha1:8'hfe]}) eu_kind = EUC_TWO;
                else if (b == 8'h8e) eu_kind = EUC_KANA;
                else if (b == 8'h8f) eu_kind = EUC_THREE;
                else return 1'b0;
                return 1'b1;
            end
            EUC_PH_TRAIL1: begin
                if (eu_kind == EUC_TWO && b inside {[8'ha1:8'hfe]}) begin
                    eu_ph = EUC_PH_LEAD;
                    return 1'b1;
                end
                if (eu_kind == EUC_KANA && b >= 8'h81) begin
                    eu_ph = EUC_PH_LEAD;
                    return 1'b1;
                end
                if (eu_kind == EUC_THREE && b >= 8'h81) begin
                    eu_ph = EUC_PH_TRAIL2;
                    return 1'b1;
                end
                return 1'b0;
            end
            EUC_PH_TRAIL2: begin
                if (b >= 8'h81) begin
                    eu_ph = EUC_PH_LEAD;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
        return 1'b0;
    endfunction

    function automatic bit utf_takes(logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        case (ut_ph)
            UTF_PH_LEAD: begin
                ut_kind = UTF_NONE;
                if (b < 8'h80) return 1'b1;
                ut_ph = UTF_PH_C1;
                if (b inside {[8'hc2:8'hdf]}) ut_kind = UTF_2B;
                else if (b == 8'he0) ut_kind = UTF_E0;
                else if (b inside {[8'he1:8'hef]}) ut_kind = UTF_3B;
                else if (b == 8'hf0) ut_kind = UTF_F0;
                else if (b inside {[8'hf1:8'hf3]}) ut_kind = UTF_4B;
                else if (b == 8'hf4) ut_kind = UTF_F4;
                else return 1'b0;
                return 1'b1;
            end
            UTF_PH_C1: begin
                if (ut_kind == UTF_NONE || ut_kind > UTF_F4) return 1'b0;
                // first continuation ranges free of overlong forms and of code points above U+10FFFF
                lo = 8'h80;
                hi = 8'hbf;
                if (ut_kind == UTF_E0) lo = 8'ha0;
                if (ut_kind == UTF_F0) lo = 8'h90;
                if (ut_kind == UTF_F4) hi = 8'h8f;
                if (b < lo || b > hi) return 1'b0;
                if (ut_kind == UTF_2B) ut_ph = UTF_PH_LEAD;
                else ut_ph = UTF_PH_C2;
                return 1'b1;
            end
            UTF_PH_C2: begin
                if (!(b inside {[8'h80:8'hbf]})) return 1'b0;
                if (ut_kind inside {UTF_E0, UTF_3B}) begin
                    ut_ph = UTF_PH_LEAD;
                    return 1'b1;
                end
                if (ut_kind inside {UTF_F0, UTF_4B, UTF_F4}) begin
                    ut_ph = UTF_PH_C3;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                if (ut_kind inside {UTF_F0, UTF_4B, UTF_F4} && b inside {[8'h80:8'hbf]}) begin
                    ut_ph = UTF_PH_LEAD;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    // a cleared flag keeps its validator from seeing further bytes
    function automatic void scan_byte(logic [7:0] b);
        if (flags[FLAG_ASCII] && !(b inside {[8'h20:8'h7e], [8'h09:8'h0d]}))
            flags[FLAG_ASCII] = 1'b0;
        if (flags[FLAG_JIS] && b >= 8'h80) flags[FLAG_JIS] = 1'b0;
        if (flags[FLAG_SJIS] && !sjis_takes(b)) flags[FLAG_SJIS] = 1'b0;
        if (flags[FLAG_EUC] && !euc_takes(b)) flags[FLAG_EUC] = 1'b0;
        if (flags[FLAG_UTF] && !utf_takes(b)) flags[FLAG_UTF] = 1'b0;
    endfunction

    function automatic void classify_byte(logic [7:0] b, logic last);
        t_verdict v;
        if (!halted) begin
            if (b == 8'h00) halted = 1'b1;
            else if (text_len < TEXT_MAX) begin
                scan_byte(b);
                text_len++;
            end
        end
        if (last) begin
            v.mask = flags;
            v.code = ENC_UNKNOWN;
            if (flags[FLAG_ASCII]) v.code = ENC_ASCII;
            else if (flags[FLAG_JIS]) v.code = ENC_JIS;
            else if (flags[FLAG_UTF]) v.code = ENC_UTF;
            else if (prefer_euc) begin
                if (flags[FLAG_EUC]) v.code = ENC_EUC;
                else if (flags[FLAG_SJIS]) v.code = ENC_SJIS;
            end else begin
                if (flags[FLAG_SJIS]) v.code = ENC_SJIS;
                else if (flags[FLAG_EUC]) v.code = ENC_EUC;
            end
            verdict_q.push_back(v);
            reset_scan();
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            tx_offer = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                classify_byte(i_text_byte, i_is_last);
                tx_offer = 1'b0;
                tx_wait = tx_idle_on ? $urandom_range(4, 0) : 0;
            end
            if (!tx_offer) begin
                if (tx_wait > 0) tx_wait--;
                else if (byte_q.size() > 0) begin
                    tx_item = byte_q.pop_front();
                    i_text_byte <= tx_item.text;
                    i_is_last   <= tx_item.last;
                    tx_offer = 1'b1;
                end
            end
            i_in_valid <= tx_offer;
        end
    end

    // receiver and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: code %0d mask %b",
                                 o_encoding_code, o_valid_mask);
                end else begin
                    seen_want = verdict_q.pop_front();
                    if (o_encoding_code !== seen_want.code ||
                        o_valid_mask !== seen_want.mask) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("result: expected code %0d mask %b, got code %0d mask %b",
                                     seen_want.code, seen_want.mask,
                                     o_encoding_code, o_valid_mask);
                    end
                end
                rx_wait = rx_idle_on ? $urandom_range(4, 0) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_out_stall <= long_hold || (rx_wait > 0);
        end
    end

    // long receiver hold-off so that the input side backs up
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            long_hold <= 1'b1;
            hold_left--;
        end else begin
            long_hold <= 1'b0;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("japanese_text_encoding_detector: mismatch");
        $finish;
    end

    function automatic logic [7:0] pick(int unsigned lo, int unsigned hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] cont_byte();
        return pick(8'h80, 8'hbf);
    endfunction

    function automatic void queue_text();
        foreach (text_buf[i])
            byte_q.push_back('{text: text_buf[i], last: (i == text_buf.size() - 1)});
        queued_bytes += text_buf.size();
        text_buf.delete();
    endfunction

    // one character of the given flavor, appended to the text buffer
    function automatic void add_char(t_flavor fl);
        int unsigned sel;
        sel = $urandom_range(7, 0);
        case (fl)
            FL_ASCII: begin
                if (sel == 0) text_buf.push_back(pick(8'h09, 8'h0d));
                else text_buf.push_back(pick(8'h20, 8'h7e));
            end
            FL_JIS: begin
                if (sel == 0) text_buf = {text_buf, 8'h1b, 8'h24, 8'h42};
                else if (sel == 1) text_buf = {text_buf, 8'h1b, 8'h28, 8'h42};
                else if (sel == 2) text_buf.push_back(pick(8'h01, 8'h7f));
                else text_buf = {text_buf, pick(8'h21, 8'h7e), pick(8'h21, 8'h7e)};
            end
            FL_SJIS: begin
                if (sel < 2) text_buf.push_back(pick(8'ha1, 8'hdf));
                else if (sel == 2) text_buf.push_back(pick(8'h20, 8'h7e));
                else begin
                    text_buf.push_back(sel[0] ? pick(8'h81, 8'h9f) : pick(8'he0, 8'hef));
                    text_buf.push_back($urandom_range(1, 0) ? pick(8'h40, 8'h7e)
                                                            : pick(8'h80, 8'hfc));
                end
            end
            FL_EUC: begin
                if (sel < 3) text_buf = {text_buf, pick(8'ha1, 8'hfe), pick(8'ha1, 8'hfe)};
                else if (sel < 5) text_buf = {text_buf, 8'h8e, pick(8'h81, 8'hff)};
                else if (sel < 7)
                    text_buf = {text_buf, 8'h8f, pick(8'h81, 8'hff), pick(8'h81, 8'hff)};
                else text_buf.push_back(pick(8'h20, 8'h7e));
            end
            FL_UTF: begin
                case (sel)
                    0: text_buf.push_back(pick(8'h20, 8'h7e));
                    1: text_buf = {text_buf, pick(8'hc2, 8'hdf), cont_byte()};
                    2: text_buf = {text_buf, 8'he0, pick(8'ha0, 8'hbf), cont_byte()};
                    3: text_buf = {text_buf, pick(8'he1, 8'hef), cont_byte(), cont_byte()};
                    4: text_buf = {text_buf, 8'hf0, pick(8'h90, 8'hbf), cont_byte(),
                                   cont_byte()};
                    5: text_buf = {text_buf, pick(8'hf1, 8'hf3), cont_byte(), cont_byte(),
                                   cont_byte()};
                    default: text_buf = {text_buf, 8'hf4, pick(8'h80, 8'h8f), cont_byte(),
                                         cont_byte()};
                endcase
            end
            default: text_buf.push_back(pick(8'h01, 8'hff));
        endcase
    endfunction

    function automatic t_flavor pick_flavor();
        case ($urandom_range(9, 0))
            0, 1:    return FL_ASCII;
            2:       return FL_JIS;
            3, 4:    return FL_SJIS;
            5, 6:    return FL_EUC;
            7, 8:    return FL_UTF;
            default: return FL_NOISE;
        endcase
    endfunction

    // mostly well-formed strings, some damaged, cut short or zero-terminated
    function automatic void random_text();
        t_flavor     fl;
        int unsigned n;
        int unsigned r;
        fl = pick_flavor();
        n  = $urandom_range(6, 1);
        repeat (n) add_char(fl);
        r = $urandom_range(99, 0);
        if (r < 12)
            text_buf.insert($urandom_range(text_buf.size(), 0), pick(8'h01, 8'hff));
        else if (r < 16 && text_buf.size() > 1)
            void'(text_buf.pop_back());
        else if (r < 20)
            text_buf.insert($urandom_range(text_buf.size(), 0), 8'h00);
        else if (r < 24)
            text_buf[$urandom_range(text_buf.size() - 1, 0)] = pick(8'h01, 8'hff);
        queue_text();
    endfunction

    // string past the length cap, the tail including the last byte is ignored
    function automatic void long_text(t_flavor fl);
        while (text_buf.size() < TEXT_MAX) add_char(fl);
        while (text_buf.size() > TEXT_MAX) void'(text_buf.pop_back());
        repeat ($urandom_range(6, 1)) text_buf.push_back(pick(8'h80, 8'hff));
        queue_text();
    endfunction

    task automatic random_phase(int n_bytes);
        int goal;
        goal = queued_bytes + n_bytes;
        while (queued_bytes < goal) random_text();
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || i_in_valid || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_prefer(logic v);
        @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_prefer_eucjp <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        prefer_euc = v;
    endtask

    initial begin
        reset_scan();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed strings at the reset preference
        text_buf = '{8'h09};                      queue_text();
        text_buf = '{8'h7f};                      queue_text();
        text_buf = '{8'hff};                      queue_text();
        text_buf = '{8'h82, 8'ha0};               queue_text();
        text_buf = '{8'ha4, 8'ha2};               queue_text();
        text_buf = '{8'h8f, 8'ha1, 8'ha1};        queue_text();
        text_buf = '{8'he3, 8'h81, 8'h82};        queue_text();
        text_buf = '{8'hf4, 8'h8f, 8'hbf, 8'hbf}; queue_text();
        text_buf = '{8'h41, 8'h00, 8'hff};        queue_text();
        text_buf = '{8'h00};                      queue_text();
        text_buf = '{8'he3};                      queue_text();
        wait_drained();

        write_prefer(1'b1);
        random_phase(200);
        wait_drained();

        // back-to-back traffic with one long receiver hold-off
        write_prefer(1'b0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_left  = LONG_HOLD;
        random_phase(200);
        wait_drained();

        write_prefer(1'b1);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        long_text(FL_ASCII);
        long_text(pick_flavor());
        random_phase(150);
        wait_drained();

        if (fail_count == 0 && verdict_q.size() == 0)
            $display("japanese_text_encoding_detector: match");
        else
            $display("japanese_text_encoding_detector: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/jted_pkg.sv
hw/rtl/jted_validate.sv
hw/rtl/japanese_text_encoding_detector.sv
dv/japanese_text_encoding_detector_tb.sv
